// ----- hdl/vmps_pkg.sv -----
// Shared types and codes for the valve and motor phase sequencer.
`default_nettype none
package vmps_pkg;

    localparam int unsigned CFG_COUNT     = 8;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned TIME_W        = 16;
    localparam int unsigned SAMPLE_W      = 12;
    localparam int unsigned SUM_W         = 15;
    localparam int unsigned TAKEN_W       = 4;
    localparam int unsigned SAMPLE_SHIFT  = 3;

    localparam logic [TIME_W-1:0]  ADC_START_MS = 16'd10;
    localparam logic [TAKEN_W-1:0] SAMPLE_COUNT = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FWD_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REV_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REV_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPRAY_LEAD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPRAY_OPEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPRAY_TAIL = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VALVE_PER  = 3'd7;

    // input kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_EDGE    = 2'd1;
    localparam logic [1:0] KIND_COMMAND = 2'd2;
    localparam logic [1:0] KIND_SAMPLE  = 2'd3;

    // command targets
    localparam logic [2:0] MODE_TIMED   = 3'd0;
    localparam logic [2:0] MODE_ENCODER = 3'd1;
    localparam logic [2:0] MODE_SPRAY   = 3'd2;
    localparam logic [2:0] MODE_VALVE   = 3'd3;
    localparam logic [2:0] MODE_MAN_FWD = 3'd4;
    localparam logic [2:0] MODE_MAN_REV = 3'd5;

    // motor drive
    localparam logic [1:0] DRIVE_BRAKE = 2'd0;
    localparam logic [1:0] DRIVE_FWD   = 2'd1;
    localparam logic [1:0] DRIVE_REV   = 2'd2;

    // phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_TIMED_FWD  = 4'd1;
    localparam logic [3:0] PH_TIMED_REV  = 4'd2;
    localparam logic [3:0] PH_ENC_FWD    = 4'd3;
    localparam logic [3:0] PH_ENC_REV    = 4'd4;
    localparam logic [3:0] PH_SPRAY_LEAD = 4'd5;
    localparam logic [3:0] PH_SPRAY_OPEN = 4'd6;
    localparam logic [3:0] PH_SPRAY_TAIL = 4'd7;
    localparam logic [3:0] PH_VALVE_WAIT = 4'd8;
    localparam logic [3:0] PH_VALVE_OPEN = 4'd9;

    typedef struct packed {
        logic [TIME_W-1:0] fwd_time_ms;
        logic [TIME_W-1:0] rev_time_ms;
        logic [TIME_W-1:0] fwd_edge_limit;
        logic [TIME_W-1:0] rev_edge_limit;
        logic [TIME_W-1:0] spray_lead_ms;
        logic [TIME_W-1:0] spray_open_ms;
        logic [TIME_W-1:0] spray_tail_ms;
        logic [TIME_W-1:0] valve_period_ms;
    } vmps_cfg_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [2:0]          mode;
        logic                run;
        logic [SAMPLE_W-1:0] adc_sample;
    } vmps_item_t;

endpackage
`default_nettype wire

// ----- hdl/valve_motor_phase_sequencer_unit.sv -----
// Top level of the valve and motor phase sequencer.
//
// Takes one event transaction (tick, encoder edge, command or ADC sample) per
// clock while the result is not stalled, and returns exactly one result
// transaction for each. The event is captured in an input register, then a
// state update writes the sequencer state, which is the result register.
// Throughput is one transaction per cycle while the result is not stalled,
// set by that single state update; a stalled result holds the input register,
// which still accepts one more transaction. Configuration writes are always
// ready and must only occur while the block is idle.
`default_nettype none
module valve_motor_phase_sequencer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vmps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vmps_pkg::TIME_W-1:0]    cfg_data,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire logic [1:0]                     kind,
    input  wire logic [2:0]                     mode,
    input  wire logic                           run,
    input  wire logic [11:0]                    adc_sample,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic [1:0]                          motor_drive,
    output logic                                enable_one,
    output logic                                enable_two,
    output logic [3:0]                          phase,
    output logic [15:0]                         position,
    output logic [11:0]                         adc_mean,
    output logic                                rejected
);
    import vmps_pkg::*;

    vmps_cfg_t  cfg;
    vmps_item_t item_in;
    vmps_item_t held_item;
    logic       held_valid;
    logic       take;

    assign item_in.kind       = kind;
    assign item_in.mode       = mode;
    assign item_in.run        = run;
    assign item_in.adc_sample = adc_sample;

    vmps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vmps_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_in    (item_in),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    vmps_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .held_valid   (held_valid),
        .held_item    (held_item),
        .take         (take),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .motor_drive  (motor_drive),
        .enable_one   (enable_one),
        .enable_two   (enable_two),
        .phase        (phase),
        .position     (position),
        .adc_mean     (adc_mean),
        .rejected     (rejected)
    );

endmodule
`default_nettype wire

// ----- hdl/vmps_cfg_regs.sv -----
// Configuration register file for the sequencer timing and limits.
`default_nettype none
module vmps_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [vmps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vmps_pkg::TIME_W-1:0]    cfg_data,
    output vmps_pkg::vmps_cfg_t                 cfg
);
    import vmps_pkg::*;

    vmps_cfg_t cfg_reg;
    vmps_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FWD_TIME:   cfg_next.fwd_time_ms     = cfg_data;
                REG_REV_TIME:   cfg_next.rev_time_ms     = cfg_data;
                REG_FWD_LIMIT:  cfg_next.fwd_edge_limit  = cfg_data;
                REG_REV_LIMIT:  cfg_next.rev_edge_limit  = cfg_data;
                REG_SPRAY_LEAD: cfg_next.spray_lead_ms   = cfg_data;
                REG_SPRAY_OPEN: cfg_next.spray_open_ms   = cfg_data;
                REG_SPRAY_TAIL: cfg_next.spray_tail_ms   = cfg_data;
                REG_VALVE_PER:  cfg_next.valve_period_ms = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fwd_time_ms     <= 16'd33;
            cfg_reg.rev_time_ms     <= 16'd66;
            cfg_reg.fwd_edge_limit  <= 16'd100;
            cfg_reg.rev_edge_limit  <= 16'd50;
            cfg_reg.spray_lead_ms   <= 16'd50;
            cfg_reg.spray_open_ms   <= 16'd100;
            cfg_reg.spray_tail_ms   <= 16'd75;
            cfg_reg.valve_period_ms <= 16'd50;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/vmps_in_stage.sv -----
// Input register stage holding one event transaction.
`default_nettype none
module vmps_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire vmps_pkg::vmps_item_t item_in,
    input  wire logic                 take,
    output logic                      held_valid,
    output vmps_pkg::vmps_item_t      held_item
);
    import vmps_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    vmps_item_t item_reg;

    assign item_ready = !valid_reg || take;
    assign valid_next = (item_valid && item_ready) || (valid_reg && !take);
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/vmps_core.sv -----
// Sequencer state update; the state registers double as the result register.
`default_nettype none
module vmps_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vmps_pkg::vmps_cfg_t  cfg,
    input  wire logic                 held_valid,
    input  wire vmps_pkg::vmps_item_t held_item,
    output logic                      take,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic [1:0]                motor_drive,
    output logic                      enable_one,
    output logic                      enable_two,
    output logic [3:0]                phase,
    output logic [15:0]               position,
    output logic [11:0]               adc_mean,
    output logic                      rejected
);
    import vmps_pkg::*;

    logic [3:0]          phase_reg,     phase_next;
    logic [TIME_W-1:0]   time_left_reg, time_left_next;
    logic [15:0]         edge_reg,      edge_next;
    logic [1:0]          drive_reg,     drive_next;
    logic                en_one_reg,    en_one_next;
    logic                en_two_reg,    en_two_next;
    logic [SUM_W-1:0]    sum_reg,       sum_next;
    logic [TAKEN_W-1:0]  taken_reg,     taken_next;
    logic [SAMPLE_W-1:0] mean_reg,      mean_next;
    logic                rej_reg,       rej_next;
    logic                out_valid_reg, out_valid_next;

    logic [15:0]         edge_plus;
    logic [TIME_W-1:0]   open_len;
    logic                busy;

    assign take           = held_valid && (!out_valid_reg || result_ready);
    assign out_valid_next = take || (out_valid_reg && !result_ready);

    assign edge_plus = edge_reg + 16'd1;
    assign busy      = (phase_reg != PH_IDLE);
    assign open_len  = (cfg.valve_period_ms >= ADC_START_MS)
                       ? (cfg.valve_period_ms - ADC_START_MS) : '0;

    always_comb
    begin
        phase_next     = phase_reg;
        time_left_next = time_left_reg;
        edge_next      = edge_reg;
        drive_next     = drive_reg;
        en_one_next    = en_one_reg;
        en_two_next    = en_two_reg;
        sum_next       = sum_reg;
        taken_next     = taken_reg;
        mean_next      = mean_reg;
        rej_next       = rej_reg;
        if (take)
        begin
            rej_next = 1'b0;
            unique case (held_item.kind)
                KIND_TICK:
                begin
                    if (phase_reg != PH_IDLE && phase_reg != PH_ENC_FWD
                        && phase_reg != PH_ENC_REV)
                    begin
                        if (time_left_reg > 16'd1)
                        begin
                            time_left_next = time_left_reg - 16'd1;
                        end
                        else
                        begin
                            unique case (phase_reg)
                                PH_TIMED_FWD:
                                begin
                                    drive_next     = DRIVE_REV;
                                    en_one_next    = 1'b0;
                                    time_left_next = cfg.rev_time_ms;
                                    phase_next     = PH_TIMED_REV;
                                end
                                PH_SPRAY_LEAD:
                                begin
                                    en_one_next    = 1'b1;
                                    time_left_next = cfg.spray_open_ms;
                                    phase_next     = PH_SPRAY_OPEN;
                                end
                                PH_SPRAY_OPEN:
                                begin
                                    en_one_next    = 1'b0;
                                    time_left_next = cfg.spray_tail_ms;
                                    phase_next     = PH_SPRAY_TAIL;
                                end
                                PH_VALVE_WAIT:
                                begin
                                    taken_next     = '0;
                                    sum_next       = '0;
                                    time_left_next = open_len;
                                    phase_next     = PH_VALVE_OPEN;
                                end
                                PH_TIMED_REV:
                                begin
                                    drive_next     = DRIVE_BRAKE;
                                    phase_next     = PH_IDLE;
                                    time_left_next = '0;
                                end
                                PH_SPRAY_TAIL:
                                begin
                                    en_two_next    = 1'b0;
                                    phase_next     = PH_IDLE;
                                    time_left_next = '0;
                                end
                                PH_VALVE_OPEN:
                                begin
                                    en_one_next    = 1'b0;
                                    phase_next     = PH_IDLE;
                                    time_left_next = '0;
                                end
                                default:
                                begin
                                    phase_next     = PH_IDLE;
                                    time_left_next = '0;
                                end
                            endcase
                        end
                    end
                end
                KIND_EDGE:
                begin
                    edge_next = edge_plus;
                    if (phase_reg == PH_ENC_FWD)
                    begin
                        if (edge_plus > cfg.fwd_edge_limit)
                        begin
                            en_one_next = 1'b0;
                            edge_next   = '0;
                            drive_next  = DRIVE_REV;
                            phase_next  = PH_ENC_REV;
                        end
                    end
                    else if (phase_reg == PH_ENC_REV)
                    begin
                        if (edge_plus > cfg.rev_edge_limit)
                        begin
                            drive_next     = DRIVE_BRAKE;
                            phase_next     = PH_IDLE;
                            time_left_next = '0;
                        end
                    end
                end
                KIND_COMMAND:
                begin
                    if (held_item.mode == MODE_MAN_REV)
                    begin
                        if (busy)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            drive_next = held_item.run ? DRIVE_REV : DRIVE_BRAKE;
                        end
                    end
                    else if (held_item.mode > MODE_MAN_REV)
                    begin
                        rej_next = 1'b0;
                    end
                    else if (held_item.run)
                    begin
                        if (busy)
                        begin
                            rej_next = 1'b1;
                        end
                        else
                        begin
                            unique case (held_item.mode)
                                MODE_TIMED:
                                begin
                                    edge_next      = '0;
                                    en_one_next    = 1'b1;
                                    drive_next     = DRIVE_FWD;
                                    time_left_next = cfg.fwd_time_ms;
                                    phase_next     = PH_TIMED_FWD;
                                end
                                MODE_ENCODER:
                                begin
                                    edge_next      = '0;
                                    en_one_next    = 1'b1;
                                    drive_next     = DRIVE_FWD;
                                    time_left_next = '0;
                                    phase_next     = PH_ENC_FWD;
                                end
                                MODE_SPRAY:
                                begin
                                    en_two_next    = 1'b1;
                                    time_left_next = cfg.spray_lead_ms;
                                    phase_next     = PH_SPRAY_LEAD;
                                end
                                MODE_VALVE:
                                begin
                                    if (cfg.valve_period_ms < ADC_START_MS)
                                    begin
                                        rej_next = 1'b1;
                                    end
                                    else
                                    begin
                                        en_one_next    = 1'b1;
                                        mean_next      = '0;
                                        taken_next     = SAMPLE_COUNT;
                                        sum_next       = '0;
                                        time_left_next = ADC_START_MS;
                                        phase_next     = PH_VALVE_WAIT;
                                    end
                                end
                                default:
                                begin
                                    en_one_next = 1'b1;
                                    drive_next  = DRIVE_FWD;
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        unique case (held_item.mode)
                            MODE_TIMED, MODE_ENCODER:
                            begin
                                en_one_next    = 1'b0;
                                drive_next     = DRIVE_BRAKE;
                                phase_next     = PH_IDLE;
                                time_left_next = '0;
                            end
                            MODE_SPRAY:
                            begin
                                en_one_next    = 1'b0;
                                en_two_next    = 1'b0;
                                phase_next     = PH_IDLE;
                                time_left_next = '0;
                            end
                            MODE_VALVE:
                            begin
                                en_one_next    = 1'b0;
                                phase_next     = PH_IDLE;
                                time_left_next = '0;
                            end
                            default:
                            begin
                                drive_next = DRIVE_BRAKE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    if (taken_reg < SAMPLE_COUNT)
                    begin
                        sum_next   = sum_reg + SUM_W'(held_item.adc_sample);
                        taken_next = taken_reg + 4'd1;
                        if (taken_next >= SAMPLE_COUNT)
                        begin
                            mean_next = sum_next[SUM_W-1:SAMPLE_SHIFT];
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            time_left_reg <= '0;
            edge_reg      <= '0;
            drive_reg     <= DRIVE_BRAKE;
            en_one_reg    <= 1'b0;
            en_two_reg    <= 1'b0;
            sum_reg       <= '0;
            taken_reg     <= SAMPLE_COUNT;
            mean_reg      <= '0;
            rej_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            time_left_reg <= time_left_next;
            edge_reg      <= edge_next;
            drive_reg     <= drive_next;
            en_one_reg    <= en_one_next;
            en_two_reg    <= en_two_next;
            sum_reg       <= sum_next;
            taken_reg     <= taken_next;
            mean_reg      <= mean_next;
            rej_reg       <= rej_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign motor_drive  = drive_reg;
    assign enable_one   = en_one_reg;
    assign enable_two   = en_two_reg;
    assign phase        = phase_reg;
    assign position     = edge_reg;
    assign adc_mean     = mean_reg;
    assign rejected     = rej_reg;

`ifndef SYNTHESIS
    // a stalled result must not be overwritten by a later transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |=>
            ($stable(phase_reg) && $stable(edge_reg) && $stable(drive_reg)
             && $stable(mean_reg) && $stable(rej_reg)))
        else $error("result changed while stalled");

    // untimed phases never carry a pending count
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_ENC_FWD || phase_reg == PH_ENC_REV)
            |-> (time_left_reg == '0))
        else $error("time_left nonzero in untimed phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= SAMPLE_COUNT)
        else $error("sample counter overran");

    // a refused command leaves the phase alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && rej_next) |=> $stable(phase_reg))
        else $error("rejected command changed phase");
`endif

endmodule
`default_nettype wire

// ----- verif/valve_motor_phase_sequencer_unit_tb.sv -----
// Self-checking testbench for the valve and motor phase sequencer: queued stimulus, prediction.
module valve_motor_phase_sequencer_unit_tb;
    import vmps_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 6;
    localparam int PHASE_ITEMS     = 115;

    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [1:0]          drive;
        logic                en_one;
        logic                en_two;
        logic [3:0]          phase;
        logic [15:0]         position;
        logic [SAMPLE_W-1:0] mean;
        logic                rejected;
    } drive_outputs_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_FWD_TIME;
    logic [TIME_W-1:0]    cfg_data     = '0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    logic [1:0]           kind         = KIND_TICK;
    logic [2:0]           mode         = MODE_TIMED;
    logic                 run          = 1'b0;
    logic [SAMPLE_W-1:0]  adc_sample   = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [1:0]           motor_drive;
    logic                 enable_one;
    logic                 enable_two;
    logic [3:0]           phase;
    logic [15:0]          position;
    logic [11:0]          adc_mean;
    logic                 rejected;

    // sequencer state as predicted
    vmps_cfg_t seq_cfg = '{fwd_time_ms: 16'd33, rev_time_ms: 16'd66,
                           fwd_edge_limit: 16'd100, rev_edge_limit: 16'd50,
                           spray_lead_ms: 16'd50, spray_open_ms: 16'd100,
                           spray_tail_ms: 16'd75, valve_period_ms: 16'd50};
    logic [3:0]          seq_phase  = PH_IDLE;
    logic [TIME_W-1:0]   seq_left   = '0;
    logic [15:0]         seq_pos    = '0;
    logic [1:0]          seq_drive  = DRIVE_BRAKE;
    logic                seq_en_one = 1'b0;
    logic                seq_en_two = 1'b0;
    logic [SUM_W-1:0]    seq_sum    = '0;
    logic [TAKEN_W-1:0]  seq_taken  = SAMPLE_COUNT;
    logic [SAMPLE_W-1:0] seq_mean   = '0;

    vmps_item_t     event_queue[$];
    drive_outputs_t predicted_outputs[$];
    vmps_item_t     current_item;
    drive_outputs_t oldest;

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned refused_count  = 0;
    int unsigned means_done     = 0;
    int unsigned settings_count = 1;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_off_left  = 0;
    bit          send_hold      = 1'b0;
    bit          hold_off_armed = 1'b0;
    bit          hold_off_taken = 1'b0;

    valve_motor_phase_sequencer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .mode         (mode),
        .run          (run),
        .adc_sample   (adc_sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .motor_drive  (motor_drive),
        .enable_one   (enable_one),
        .enable_two   (enable_two),
        .phase        (phase),
        .position     (position),
        .adc_mean     (adc_mean),
        .rejected     (rejected)
    );

    function automatic drive_outputs_t step_sequencer(input vmps_item_t it);
        drive_outputs_t o;
        logic           refused;
        refused = 1'b0;
        case (it.kind)
            KIND_TICK:
            begin
                if (seq_phase != PH_IDLE && seq_phase != PH_ENC_FWD && seq_phase != PH_ENC_REV)
                begin
                    if (seq_left > 1)
                    begin
                        seq_left = seq_left - 1'b1;
                    end
                    else
                    begin
                        case (seq_phase)
                            PH_TIMED_FWD:
                            begin
                                seq_drive  = DRIVE_REV;
                                seq_en_one = 1'b0;
                                seq_left   = seq_cfg.rev_time_ms;
                                seq_phase  = PH_TIMED_REV;
                            end
                            PH_TIMED_REV:
                            begin
                                seq_drive = DRIVE_BRAKE;
                                seq_phase = PH_IDLE;
                                seq_left  = '0;
                            end
                            PH_SPRAY_LEAD:
                            begin
                                seq_en_one = 1'b1;
                                seq_left   = seq_cfg.spray_open_ms;
                                seq_phase  = PH_SPRAY_OPEN;
                            end
                            PH_SPRAY_OPEN:
                            begin
                                seq_en_one = 1'b0;
                                seq_left   = seq_cfg.spray_tail_ms;
                                seq_phase  = PH_SPRAY_TAIL;
                            end
                            PH_SPRAY_TAIL:
                            begin
                                seq_en_two = 1'b0;
                                seq_phase  = PH_IDLE;
                                seq_left   = '0;
                            end
                            PH_VALVE_WAIT:
                            begin
                                seq_taken = '0;
                                seq_sum   = '0;
                                seq_left  = (seq_cfg.valve_period_ms >= ADC_START_MS) ?
                                            seq_cfg.valve_period_ms - ADC_START_MS : '0;
                                seq_phase = PH_VALVE_OPEN;
                            end
                            PH_VALVE_OPEN:
                            begin
                                seq_en_one = 1'b0;
                                seq_phase  = PH_IDLE;
                                seq_left   = '0;
                            end
                            default:
                            begin
                                seq_phase = PH_IDLE;
                                seq_left  = '0;
                            end
                        endcase
                    end
                end
            end
            KIND_EDGE:
            begin
                seq_pos = seq_pos + 1'b1;
                if (seq_phase == PH_ENC_FWD)
                begin
                    if (seq_pos > seq_cfg.fwd_edge_limit)
                    begin
                        seq_en_one = 1'b0;
                        seq_pos    = '0;
                        seq_drive  = DRIVE_REV;
                        seq_phase  = PH_ENC_REV;
                    end
                end
                else if (seq_phase == PH_ENC_REV && seq_pos > seq_cfg.rev_edge_limit)
                begin
                    seq_drive = DRIVE_BRAKE;
                    seq_phase = PH_IDLE;
                    seq_left  = '0;
                end
            end
            KIND_COMMAND:
            begin
                if (it.mode == MODE_MAN_REV)
                begin
                    if (seq_phase != PH_IDLE)
                        refused = 1'b1;
                    else
                        seq_drive = it.run ? DRIVE_REV : DRIVE_BRAKE;
                end
                else if (it.mode < MODE_MAN_REV)
                begin
                    if (it.run)
                    begin
                        if (seq_phase != PH_IDLE)
                        begin
                            refused = 1'b1;
                        end
                        else
                        begin
                            case (it.mode)
                                MODE_TIMED:
                                begin
                                    seq_pos    = '0;
                                    seq_en_one = 1'b1;
                                    seq_drive  = DRIVE_FWD;
                                    seq_left   = seq_cfg.fwd_time_ms;
                                    seq_phase  = PH_TIMED_FWD;
                                end
                                MODE_ENCODER:
                                begin
                                    seq_pos    = '0;
                                    seq_en_one = 1'b1;
                                    seq_drive  = DRIVE_FWD;
                                    seq_left   = '0;
                                    seq_phase  = PH_ENC_FWD;
                                end
                                MODE_SPRAY:
                                begin
                                    seq_en_two = 1'b1;
                                    seq_left   = seq_cfg.spray_lead_ms;
                                    seq_phase  = PH_SPRAY_LEAD;
                                end
                                MODE_VALVE:
                                begin
                                    if (seq_cfg.valve_period_ms < ADC_START_MS)
                                    begin
                                        refused = 1'b1;
                                    end
                                    else
                                    begin
                                        seq_en_one = 1'b1;
                                        seq_mean   = '0;
                                        seq_taken  = SAMPLE_COUNT;
                                        seq_sum    = '0;
                                        seq_left   = ADC_START_MS;
                                        seq_phase  = PH_VALVE_WAIT;
                                    end
                                end
                                default:
                                begin
                                    seq_en_one = 1'b1;
                                    seq_drive  = DRIVE_FWD;
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        case (it.mode)
                            MODE_TIMED, MODE_ENCODER:
                            begin
                                seq_en_one = 1'b0;
                                seq_drive  = DRIVE_BRAKE;
                                seq_phase  = PH_IDLE;
                                seq_left   = '0;
                            end
                            MODE_SPRAY:
                            begin
                                seq_en_one = 1'b0;
                                seq_en_two = 1'b0;
                                seq_phase  = PH_IDLE;
                                seq_left   = '0;
                            end
                            MODE_VALVE:
                            begin
                                seq_en_one = 1'b0;
                                seq_phase  = PH_IDLE;
                                seq_left   = '0;
                            end
                            default:
                            begin
                                seq_drive = DRIVE_BRAKE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                if (seq_taken < SAMPLE_COUNT)
                begin
                    seq_sum   = seq_sum + SUM_W'(it.adc_sample);
                    seq_taken = seq_taken + 1'b1;
                    if (seq_taken >= SAMPLE_COUNT)
                    begin
                        seq_mean = seq_sum[SUM_W-1:SAMPLE_SHIFT];
                        means_done++;
                    end
                end
            end
        endcase
        if (refused)
            refused_count++;
        o.drive    = seq_drive;
        o.en_one   = seq_en_one;
        o.en_two   = seq_en_two;
        o.phase    = seq_phase;
        o.position = seq_pos;
        o.mean     = seq_mean;
        o.rejected = refused;
        return o;
    endfunction

    function automatic void queue_item(input logic [1:0] k, input logic [2:0] m, input logic r,
                                       input logic [SAMPLE_W-1:0] a);
        vmps_item_t it;
        it.kind       = k;
        it.mode       = m;
        it.run        = r;
        it.adc_sample = a;
        event_queue.push_back(it);
        queued_count++;
    endfunction

    function automatic void queue_event(input logic [1:0] k);
        queue_item(k, 3'($urandom_range(7)), 1'($urandom_range(1)),
                   SAMPLE_W'($urandom_range(4095)));
    endfunction

    function automatic void queue_command(input logic [2:0] m, input logic r);
        queue_item(KIND_COMMAND, m, r, SAMPLE_W'($urandom_range(4095)));
    endfunction

    function automatic vmps_cfg_t short_settings();
        vmps_cfg_t s;
        s.fwd_time_ms     = TIME_W'($urandom_range(5));
        s.rev_time_ms     = TIME_W'($urandom_range(5));
        s.fwd_edge_limit  = TIME_W'($urandom_range(8));
        s.rev_edge_limit  = TIME_W'($urandom_range(8));
        s.spray_lead_ms   = TIME_W'($urandom_range(5));
        s.spray_open_ms   = TIME_W'($urandom_range(5));
        s.spray_tail_ms   = TIME_W'($urandom_range(5));
        s.valve_period_ms = ADC_START_MS + TIME_W'($urandom_range(4));
        return s;
    endfunction

    // mostly whole runs with random content, some noise and broken runs
    task automatic queue_random_items(input int unsigned target);
        int unsigned first;
        int unsigned pick;
        int unsigned roll;
        int unsigned len;
        logic [2:0]  m;
        first = queued_count;
        while (queued_count - first < target)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                queue_item(2'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                           SAMPLE_W'($urandom_range(4095)));
            end
            else if (pick < 18)
            begin
                queue_command(3'($urandom_range(MODE_UNUSED_HI, MODE_MAN_FWD)),
                              1'($urandom_range(1)));
            end
            else
            begin
                m = 3'($urandom_range(MODE_VALVE, MODE_TIMED));
                queue_command(m, 1'b1);
                len = (m == MODE_VALVE) ? $urandom_range(30, 12) : $urandom_range(20, 3);
                repeat (len)
                begin
                    roll = $urandom_range(99);
                    if (roll < 4)
                        queue_command(3'($urandom_range(MODE_MAN_REV, MODE_TIMED)), 1'b1);
                    else if (roll < 8)
                        queue_command(3'($urandom_range(MODE_VALVE, MODE_TIMED)), 1'b0);
                    else if (roll < 14)
                        queue_event(2'($urandom_range(3)));
                    else if (m == MODE_ENCODER)
                        queue_event(KIND_EDGE);
                    else if (m == MODE_VALVE && roll < 50)
                        queue_event(KIND_SAMPLE);
                    else
                        queue_event(KIND_TICK);
                end
            end
        end
    endtask

    task automatic settle();
        do
            @(posedge clk);
        while (event_queue.size() != 0 || accepted_count != queued_count ||
               predicted_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FWD_TIME:   seq_cfg.fwd_time_ms     = value;
            REG_REV_TIME:   seq_cfg.rev_time_ms     = value;
            REG_FWD_LIMIT:  seq_cfg.fwd_edge_limit  = value;
            REG_REV_LIMIT:  seq_cfg.rev_edge_limit  = value;
            REG_SPRAY_LEAD: seq_cfg.spray_lead_ms   = value;
            REG_SPRAY_OPEN: seq_cfg.spray_open_ms   = value;
            REG_SPRAY_TAIL: seq_cfg.spray_tail_ms   = value;
            default:        seq_cfg.valve_period_ms = value;
        endcase
    endtask

    task automatic begin_phase(input vmps_cfg_t s, input int unsigned send_pct,
                               input int unsigned recv_pct);
        cfg_write(REG_FWD_TIME,   s.fwd_time_ms);
        cfg_write(REG_REV_TIME,   s.rev_time_ms);
        cfg_write(REG_FWD_LIMIT,  s.fwd_edge_limit);
        cfg_write(REG_REV_LIMIT,  s.rev_edge_limit);
        cfg_write(REG_SPRAY_LEAD, s.spray_lead_ms);
        cfg_write(REG_SPRAY_OPEN, s.spray_open_ms);
        cfg_write(REG_SPRAY_TAIL, s.spray_tail_ms);
        cfg_write(REG_VALVE_PER,  s.valve_period_ms);
        settings_count++;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            error_count++;
        end
    endfunction

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // input side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                predicted_outputs.push_back(step_sequencer(current_item));
                accepted_count++;
            end
            if (!item_valid || item_ready)
            begin
                if (event_queue.size() != 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    current_item = event_queue.pop_front();
                    item_valid <= 1'b1;
                    kind       <= current_item.kind;
                    mode       <= current_item.mode;
                    run        <= current_item.run;
                    adc_sample <= current_item.adc_sample;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    $error("result transaction with nothing predicted");
                    error_count++;
                end
                else
                begin
                    oldest = predicted_outputs.pop_front();
                    check_field("motor_drive", 16'(oldest.drive), 16'(motor_drive));
                    check_field("enable_one", 16'(oldest.en_one), 16'(enable_one));
                    check_field("enable_two", 16'(oldest.en_two), 16'(enable_two));
                    check_field("phase", 16'(oldest.phase), 16'(phase));
                    check_field("position", oldest.position, position);
                    check_field("adc_mean", 16'(oldest.mean), 16'(adc_mean));
                    check_field("rejected", 16'(oldest.rejected), 16'(rejected));
                end
            end
            if (hold_off_armed && !hold_off_taken)
            begin
                hold_off_taken = 1'b1;
                hold_off_left  = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial
    begin
        vmps_cfg_t s;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset register values
        queue_item(KIND_SAMPLE, 3'($urandom_range(7)), 1'($urandom_range(1)), 12'hFFF);
        queue_command(MODE_MAN_REV, 1'b1);
        queue_command(MODE_MAN_FWD, 1'b1);
        queue_command(MODE_MAN_FWD, 1'b0);
        queue_command(MODE_UNUSED_LO, 1'b1);
        queue_command(MODE_UNUSED_HI, 1'b0);
        queue_command(MODE_VALVE, 1'b1);
        queue_command(MODE_TIMED, 1'b1);
        queue_command(MODE_MAN_REV, 1'b0);
        repeat (ADC_START_MS) queue_event(KIND_TICK);
        repeat (SAMPLE_COUNT)
            queue_item(KIND_SAMPLE, 3'($urandom_range(7)), 1'($urandom_range(1)), 12'hFFF);
        queue_command(MODE_VALVE, 1'b0);
        settle();

        // full rate, with one pause of the sender until everything has come back
        begin_phase(short_settings(), 0, 0);
        queue_random_items(PHASE_ITEMS);
        while (event_queue.size() > PHASE_ITEMS / 2) @(posedge clk);
        send_hold = 1'b1;
        do
            @(posedge clk);
        while (accepted_count + event_queue.size() != queued_count ||
               predicted_outputs.size() != 0);
        send_hold = 1'b0;
        settle();

        // all lengths and limits zero, valve period one short of the minimum
        s = '0;
        s.valve_period_ms = ADC_START_MS - 1'b1;
        begin_phase(s, 63, 0);
        queue_random_items(PHASE_ITEMS);
        settle();

        // stalled receiver, with one long hold-off to back up the input
        begin_phase(short_settings(), 0, 63);
        queue_random_items(PHASE_ITEMS);
        hold_off_armed = 1'b1;
        settle();

        begin_phase(short_settings(), 18, 18);
        queue_random_items(PHASE_ITEMS);
        settle();

        // largest lengths and limits
        s.fwd_time_ms     = 16'hFFFF;
        s.rev_time_ms     = 16'hFFFF;
        s.fwd_edge_limit  = 16'hFFFE;
        s.rev_edge_limit  = 16'hFFFE;
        s.spray_lead_ms   = 16'hFFFF;
        s.spray_open_ms   = 16'hFFFF;
        s.spray_tail_ms   = 16'hFFFF;
        s.valve_period_ms = 16'hFFFF;
        begin_phase(s, 0, 0);
        queue_random_items(60);
        settle();

        $display("Covered %0d transactions over %0d register settings: %0d refused commands,",
                 accepted_count, settings_count, refused_count);
        $display("%0d completed ADC averages, with lengths and limits from zero to maximum.",
                 means_done);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/vmps_pkg.sv
hdl/vmps_cfg_regs.sv
hdl/vmps_in_stage.sv
hdl/vmps_core.sv
hdl/valve_motor_phase_sequencer_unit.sv
verif/valve_motor_phase_sequencer_unit_tb.sv
